// File: rtl/dhfk_pkg.sv
`timescale 1ns / 1ps

package dhfk_pkg;

    localparam int JOINTS       = 6;
    localparam int ANGLE_W      = 16;
    localparam int ANGLE_BITS_D = 16;
    localparam int REG_W        = 21;
    localparam int OUT_W        = 23;
    localparam int TRIG_W       = 18;
    localparam int VEC_W        = 28;
    localparam int STEPS        = 5;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam int          ZERO_BAND   = 4;

    // Horner divisors and the reciprocal shift that keeps each reciprocal in 32 bits.
    localparam int SIN_DIV [STEPS] = '{110, 72, 42, 20, 6};
    localparam int SIN_SH  [STEPS] = '{38, 38, 37, 36, 34};
    localparam int COS_DIV [STEPS] = '{132, 90, 56, 30, 12};
    localparam int COS_SH  [STEPS] = '{39, 38, 37, 36, 35};

    localparam int TWIST_COS [JOINTS] = '{0, 1, 1, 0, 0, 1};
    localparam int TWIST_SIN [JOINTS] = '{1, 0, 0, 1, -1, 0};

    // Trig lane: x, x squared, three per Horner step, final multiply, quadrant fold.
    localparam int TRIG_LAT = 2 + 3 * STEPS + 2;
    localparam int LINK_LAT = 3;
    localparam int PIPE_LAT = TRIG_LAT + LINK_LAT * JOINTS;

    localparam logic signed [REG_W-1:0] RST_BASE_HEIGHT = 21'sd5843;
    localparam logic signed [REG_W-1:0] RST_UPPER_ARM   = -21'sd27853;
    localparam logic signed [REG_W-1:0] RST_FOREARM     = -21'sd25706;
    localparam logic signed [REG_W-1:0] RST_WRIST1      = 21'sd7153;
    localparam logic signed [REG_W-1:0] RST_WRIST2      = 21'sd6203;
    localparam logic signed [REG_W-1:0] RST_WRIST3      = 21'sd5394;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_HEIGHT = 3'd0,
        CFG_UPPER_ARM   = 3'd1,
        CFG_FOREARM     = 3'd2,
        CFG_WRIST1      = 3'd3,
        CFG_WRIST2      = 3'd4,
        CFG_WRIST3      = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } trig_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    function automatic logic signed [TRIG_W-1:0] dead_zone(input logic signed [TRIG_W-1:0] v);
        if (v > -TRIG_W'(ZERO_BAND) && v < TRIG_W'(ZERO_BAND))
            return '0;
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VEC_W-1:0] v);
        localparam logic signed [VEC_W-1:0] MAXV = VEC_W'((1 << (OUT_W - 1)) - 1);
        localparam logic signed [VEC_W-1:0] MINV = -VEC_W'(1 << (OUT_W - 1));
        if (v > MAXV)
            return OUT_W'(MAXV);
        if (v < MINV)
            return OUT_W'(MINV);
        return OUT_W'(v);
    endfunction

endpackage

// File: rtl/dhfk_if.sv
`timescale 1ns / 1ps

interface dhfk_in_if;
    import dhfk_pkg::*;
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle_1;
    logic [ANGLE_W-1:0] angle_2;
    logic [ANGLE_W-1:0] angle_3;
    logic [ANGLE_W-1:0] angle_4;
    logic [ANGLE_W-1:0] angle_5;
    logic [ANGLE_W-1:0] angle_6;
    modport source (output valid, angle_1, angle_2, angle_3, angle_4, angle_5, angle_6,
                    input ready);
    modport sink (input valid, angle_1, angle_2, angle_3, angle_4, angle_5, angle_6,
                  output ready);
endinterface

interface dhfk_out_if;
    import dhfk_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] x_pos;
    logic signed [OUT_W-1:0] y_pos;
    logic signed [OUT_W-1:0] z_pos;
    modport source (output valid, x_pos, y_pos, z_pos, input ready);
    modport sink (input valid, x_pos, y_pos, z_pos, output ready);
endinterface

interface dhfk_cfg_if;
    import dhfk_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/dh_forward_kinematics_6dof_core.sv
`timescale 1ns / 1ps

// Six-joint forward kinematics, position only: one beat of six binary joint angles in, one
// beat of saturated Q16.16 tool x, y and z out. The block is a fully pipelined datapath that
// accepts a new beat every cycle while input ready is high; each beat passes from acceptance
// through the trig lanes and the six-link chain to the output register. Six trig lanes
// evaluate every joint's cosine and sine side by side, and the link chain merges them
// from joint six back to joint one. A two-entry output stage keeps the input open while a
// finished result waits; input ready drops only when both are full. Link offsets and
// lengths are written through the configuration channel, which is always ready and
// should be written only while no beat is in flight.
module dh_forward_kinematics_6dof_core
    import dhfk_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_D
)
(
    input  logic clk,
    input  logic rst_n,
    dhfk_in_if.sink    in_ch,
    dhfk_out_if.source out_ch,
    dhfk_cfg_if.sink   cfg_ch
);

    logic signed [REG_W-1:0] base_reg, upper_reg, fore_reg, w1_reg, w2_reg, w3_reg;
    logic signed [REG_W-1:0] a_len [JOINTS];
    logic signed [REG_W-1:0] d_off [JOINTS];
    logic [ANGLE_W-1:0]      angles [JOINTS];
    trig_t                   trig [JOINTS];
    trig_t                   trig_al [JOINTS];
    vec_t                    chain [JOINTS+1];

    logic                    en;
    logic [PIPE_LAT-1:0]     vld_reg;
    logic                    out_v_reg, skid_v_reg, take;
    logic signed [OUT_W-1:0] ox_reg, oy_reg, oz_reg, kx_reg, ky_reg, kz_reg;
    logic signed [OUT_W-1:0] px, py, pz;

    // Configuration registers.
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= RST_BASE_HEIGHT;
            upper_reg <= RST_UPPER_ARM;
            fore_reg  <= RST_FOREARM;
            w1_reg    <= RST_WRIST1;
            w2_reg    <= RST_WRIST2;
            w3_reg    <= RST_WRIST3;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_idx_t'(cfg_ch.index))
                CFG_BASE_HEIGHT: base_reg  <= $signed(cfg_ch.data);
                CFG_UPPER_ARM:   upper_reg <= $signed(cfg_ch.data);
                CFG_FOREARM:     fore_reg  <= $signed(cfg_ch.data);
                CFG_WRIST1:      w1_reg    <= $signed(cfg_ch.data);
                CFG_WRIST2:      w2_reg    <= $signed(cfg_ch.data);
                CFG_WRIST3:      w3_reg    <= $signed(cfg_ch.data);
                default:
                begin
                end
            endcase
        end
    end

    assign d_off[0] = base_reg;
    assign d_off[1] = '0;
    assign d_off[2] = '0;
    assign d_off[3] = w1_reg;
    assign d_off[4] = w2_reg;
    assign d_off[5] = w3_reg;
    assign a_len[0] = '0;
    assign a_len[1] = upper_reg;
    assign a_len[2] = fore_reg;
    assign a_len[3] = '0;
    assign a_len[4] = '0;
    assign a_len[5] = '0;

    // The whole datapath moves together; it halts only when the skid entry is occupied.
    assign en          = !skid_v_reg;
    assign in_ch.ready = en;

    assign angles[0] = in_ch.angle_1;
    assign angles[1] = in_ch.angle_2;
    assign angles[2] = in_ch.angle_3;
    assign angles[3] = in_ch.angle_4;
    assign angles[4] = in_ch.angle_5;
    assign angles[5] = in_ch.angle_6;

    // Trig lanes, then per-joint delay so that each link sees its own angle's trig values.
    for (genvar j = 0; j < JOINTS; j++)
    begin : g_lane
        localparam int DEPTH = LINK_LAT * (JOINTS - 1 - j);

        dhfk_trig_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane (
            .clk(clk), .en(en), .angle(angles[j]), .trig(trig[j])
        );

        if (DEPTH == 0)
        begin : g_direct
            assign trig_al[j] = trig[j];
        end
        else
        begin : g_delay
            trig_t dly_reg [DEPTH];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dly_reg[0] <= trig[j];
                    for (int i = 1; i < DEPTH; i++)
                        dly_reg[i] <= dly_reg[i-1];
                end
            end
            assign trig_al[j] = dly_reg[DEPTH-1];
        end
    end

    // Link chain from the tool joint back to the base joint, starting at the origin.
    assign chain[0] = '0;

    for (genvar p = 0; p < JOINTS; p++)
    begin : g_link
        localparam int J = JOINTS - 1 - p;
        dhfk_link #(.CA(TWIST_COS[J]), .SA(TWIST_SIN[J])) u_link (
            .clk(clk), .en(en), .v_in(chain[p]), .trig(trig_al[J]),
            .a_len(a_len[J]), .d_off(d_off[J]), .v_out(chain[p+1])
        );
    end

    assign px = sat_out(chain[JOINTS].x);
    assign py = sat_out(chain[JOINTS].y);
    assign pz = sat_out(chain[JOINTS].z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_ch.valid};
    end

    // Output register with one skid entry behind it.
    assign take = out_ch.ready || !out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= vld_reg[PIPE_LAT-1];
        end
        else if (en && vld_reg[PIPE_LAT-1])
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_v_reg)
            begin
                ox_reg <= kx_reg;
                oy_reg <= ky_reg;
                oz_reg <= kz_reg;
            end
            else
            begin
                ox_reg <= px;
                oy_reg <= py;
                oz_reg <= pz;
            end
        end
        else if (en)
        begin
            kx_reg <= px;
            ky_reg <= py;
            kz_reg <= pz;
        end
    end

    assign out_ch.valid = out_v_reg;
    assign out_ch.x_pos = ox_reg;
    assign out_ch.y_pos = oy_reg;
    assign out_ch.z_pos = oz_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !out_ch.ready && vld_reg[PIPE_LAT-1]))
        else $error("skid entry filled without a stalled output and a finished beat");

    a_ready_tracks_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_ch.ready && skid_v_reg) |=> (in_ch.ready && out_v_reg))
        else $error("draining the skid entry did not reopen the input");
`endif

endmodule

// File: rtl/dhfk_horner.sv
`timescale 1ns / 1ps

// One Horner step: t_out = max(0, 1.0 - ((x2 * t_in) >> 30) / DIV), three stages.
module dhfk_horner
    import dhfk_pkg::*;
#(
    parameter int DIV = 110,
    parameter int SH  = 38
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] x2,
    input  logic [30:0] t_in,
    output logic [31:0] x2_out,
    output logic [30:0] t_out
);

    localparam logic [31:0] RCP = 32'((64'd1 << SH) / 64'(DIV));

    logic [31:0] q_reg, q2_reg, est_reg;
    logic [31:0] x2a_reg, x2b_reg, x2c_reg;
    logic [30:0] t_reg, t_next;
    logic [62:0] prod_a;
    logic [63:0] prod_b;
    logic [33:0] rem;
    logic [31:0] quo;

    assign prod_a = 63'(x2) * 63'(t_in);
    assign prod_b = 64'(q_reg) * 64'(RCP);

    // The reciprocal estimate is never high and at most one low.
    always_comb
    begin
        rem = 34'(q2_reg) - 34'(est_reg) * 34'(DIV);
        quo = est_reg + ((rem >= 34'(DIV)) ? 32'd1 : 32'd0);
        if (quo > 32'(Q30_ONE))
            t_next = '0;
        else
            t_next = 31'(32'(Q30_ONE) - quo);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= prod_a[61:30];
            x2a_reg <= x2;
            est_reg <= 32'(prod_b >> SH);
            q2_reg  <= q_reg;
            x2b_reg <= x2a_reg;
            t_reg   <= t_next;
            x2c_reg <= x2b_reg;
        end
    end

    assign x2_out = x2c_reg;
    assign t_out  = t_reg;

endmodule

// File: rtl/dhfk_trig_lane.sv
`timescale 1ns / 1ps

// Pipelined cosine and sine of one joint angle, scale 2^15, near-zero values cleared.
module dhfk_trig_lane
    import dhfk_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_D
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [ANGLE_W-1:0] angle,
    output trig_t              trig
);

    localparam int DLY = 3 * STEPS;

    logic [23:0] ang_ext;
    logic [31:0] phase;
    logic [60:0] prod_x;
    logic [61:0] prod_x2;

    logic [30:0] x_reg, xb_reg;
    logic [31:0] x2_reg;
    quad_t       quad_reg, quadb_reg;

    logic [30:0] x_dly  [DLY];
    quad_t       q_dly  [DLY];

    logic [31:0] sx2 [STEPS+1];
    logic [30:0] st  [STEPS+1];
    logic [31:0] cx2 [STEPS+1];
    logic [30:0] ct  [STEPS+1];

    logic [31:0] ps_reg, pc_reg;
    quad_t       qf_reg;
    logic [61:0] prod_s, prod_c;
    logic [17:0] s_mag;
    logic signed [32:0] c30;
    logic [17:0] c_mag;
    logic signed [TRIG_W-1:0] cv, sv;
    trig_t       trig_reg, trig_next;

    assign ang_ext = 24'(angle);
    assign phase   = 32'(ang_ext[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    assign prod_x  = 61'(phase[29:0]) * 61'(HALF_PI_Q30);
    assign prod_x2 = 62'(x_reg) * 62'(x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= prod_x[60:30];
            quad_reg  <= quad_t'(phase[31:30]);
            x2_reg    <= prod_x2[61:30];
            xb_reg    <= x_reg;
            quadb_reg <= quad_reg;
            x_dly[0]  <= xb_reg;
            q_dly[0]  <= quadb_reg;
            for (int i = 1; i < DLY; i++)
            begin
                x_dly[i] <= x_dly[i-1];
                q_dly[i] <= q_dly[i-1];
            end
        end
    end

    assign sx2[0] = x2_reg;
    assign cx2[0] = x2_reg;
    assign st[0]  = Q30_ONE;
    assign ct[0]  = Q30_ONE;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        dhfk_horner #(.DIV(SIN_DIV[k]), .SH(SIN_SH[k])) u_sin (
            .clk(clk), .en(en), .x2(sx2[k]), .t_in(st[k]),
            .x2_out(sx2[k+1]), .t_out(st[k+1])
        );
        dhfk_horner #(.DIV(COS_DIV[k]), .SH(COS_SH[k])) u_cos (
            .clk(clk), .en(en), .x2(cx2[k]), .t_in(ct[k]),
            .x2_out(cx2[k+1]), .t_out(ct[k+1])
        );
    end

    assign prod_s = 62'(x_dly[DLY-1]) * 62'(st[STEPS]);
    assign prod_c = 62'(cx2[STEPS]) * 62'(ct[STEPS]);

    always_comb
    begin
        s_mag = 18'((33'(ps_reg) + 33'd16384) >> 15);
        c30   = 33'sd1073741824 - $signed(33'(pc_reg >> 1));
        if (c30 < 0)
            c_mag = '0;
        else
            c_mag = 18'((c30 + 33'sd16384) >>> 15);
        cv = $signed(c_mag);
        sv = $signed(s_mag);
        unique case (qf_reg)
            QUAD_0:
            begin
                trig_next.c = cv;
                trig_next.s = sv;
            end
            QUAD_1:
            begin
                trig_next.c = -sv;
                trig_next.s = cv;
            end
            QUAD_2:
            begin
                trig_next.c = -cv;
                trig_next.s = -sv;
            end
            QUAD_3:
            begin
                trig_next.c = sv;
                trig_next.s = -cv;
            end
            default:
            begin
                trig_next.c = cv;
                trig_next.s = sv;
            end
        endcase
        trig_next.c = dead_zone(trig_next.c);
        trig_next.s = dead_zone(trig_next.s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg   <= prod_s[61:30];
            pc_reg   <= prod_c[61:30];
            qf_reg   <= q_dly[DLY-1];
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

// File: rtl/dhfk_link.sv
`timescale 1ns / 1ps

// Applies one link transform to the running point, three stages.
module dhfk_link
    import dhfk_pkg::*;
#(
    parameter int CA = 1,
    parameter int SA = 0
)
(
    input  logic                    clk,
    input  logic                    en,
    input  vec_t                    v_in,
    input  trig_t                   trig,
    input  logic signed [REG_W-1:0] a_len,
    input  logic signed [REG_W-1:0] d_off,
    output vec_t                    v_out
);

    localparam int PW = TRIG_W + VEC_W;

    logic signed [VEC_W-1:0] u_next, w_next, z_next;
    logic signed [VEC_W-1:0] u_reg, w_reg, za_reg, zb_reg;
    trig_t                   tr_reg;
    logic signed [PW-1:0]    cu_reg, sw_reg, su_reg, cw_reg;
    logic signed [PW-1:0]    sx, sy;
    vec_t                    v_reg, v_next;

    always_comb
    begin
        u_next = v_in.x + VEC_W'(a_len);
        w_next = '0;
        z_next = VEC_W'(d_off);
        if (CA == 1)
        begin
            w_next = w_next + v_in.y;
            z_next = z_next + v_in.z;
        end
        if (SA == 1)
        begin
            w_next = w_next - v_in.z;
            z_next = z_next + v_in.y;
        end
        else if (SA == -1)
        begin
            w_next = w_next + v_in.z;
            z_next = z_next - v_in.y;
        end
    end

    // Round half away from zero from Q31 down to Q16.16.
    always_comb
    begin
        sx = cu_reg - sw_reg;
        sy = su_reg + cw_reg;
        v_next.x = VEC_W'((sx + ((sx < 0) ? PW'(16383) : PW'(16384))) >>> 15);
        v_next.y = VEC_W'((sy + ((sy < 0) ? PW'(16383) : PW'(16384))) >>> 15);
        v_next.z = zb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg  <= u_next;
            w_reg  <= w_next;
            za_reg <= z_next;
            tr_reg <= trig;
            cu_reg <= PW'(tr_reg.c) * PW'(u_reg);
            sw_reg <= PW'(tr_reg.s) * PW'(w_reg);
            su_reg <= PW'(tr_reg.s) * PW'(u_reg);
            cw_reg <= PW'(tr_reg.c) * PW'(w_reg);
            zb_reg <= za_reg;
            v_reg  <= v_next;
        end
    end

    assign v_out = v_reg;

endmodule

// File: verif/dhfk_tb_if.sv
`timescale 1ns / 1ps

// The channel interfaces come with the RTL in rtl/dhfk_if.sv. This file carries the
// testbench-side pose types that the bench shares between its driver and its monitor.
package dhfk_tb_pkg;
    import dhfk_pkg::*;

    typedef struct {
        logic [ANGLE_W-1:0] angle [JOINTS];
    } joint_angles_t;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } tool_pos_t;
endpackage

// File: verif/tb_dh_forward_kinematics_6dof_core.sv
`timescale 1ns / 1ps

module tb_dh_forward_kinematics_6dof_core;
    import dhfk_pkg::*;
    import dhfk_tb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    // Drain wait after the last result, which lets the pipeline empty.
    localparam int DRAIN_CYCLES = PIPE_LAT + 20;
    localparam logic signed [REG_W-1:0] REG_MAX = 21'sd1048575;
    localparam logic signed [REG_W-1:0] REG_MIN = -21'sd1048576;

    logic clk = 1'b0;
    logic rst_n;

    dhfk_in_if  in_ch ();
    dhfk_out_if out_ch ();
    dhfk_cfg_if cfg_ch ();

    dh_forward_kinematics_6dof_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the six link registers, indexed like the configuration channel.
    logic signed [REG_W-1:0] link_reg [JOINTS];

    // Fixed twist of each joint: +90, 0, 0, +90, -90, 0 degrees.
    localparam longint TW_COS [JOINTS] = '{0, 1, 1, 0, 0, 1};
    localparam longint TW_SIN [JOINTS] = '{1, 0, 0, 1, -1, 0};

    joint_angles_t pending_poses [$];
    tool_pos_t     expected_pos [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  fail_count;
    int  cycle_count;

    // ------------------------------------------------------------------
    // Pose predictor
    // ------------------------------------------------------------------

    // Rounds a Q30 trig value to scale 2^15; negative values clamp to zero.
    function automatic longint q30_round(input longint v);
        if (v < 0)
            v = 0;
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint near_zero_clear(input longint v);
        if (v > -ZERO_BAND && v < ZERO_BAND)
            return 0;
        return v;
    endfunction

    // Cosine and sine of a binary angle at scale 2^15, by a Horner Taylor series
    // on the angle folded into the first quadrant.
    task automatic angle_trig(input logic [ANGLE_W-1:0] ang, output longint c_out,
                              output longint s_out);
        longint sdiv [5];
        longint cdiv [5];
        logic [31:0] phase;
        logic [1:0]  quad;
        longint unsigned r;
        longint x, x2, t, s, c;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12};
        phase = 32'(ang) << (32 - ANGLE_W);
        quad = phase[31:30];
        r = longint'(phase[29:0]);
        x = longint'((r * 64'(HALF_PI_Q30)) >> 30);
        x2 = (x * x) >>> 30;
        t = longint'(Q30_ONE);
        for (int k = 0; k < 5; k++)
        begin
            t = longint'(Q30_ONE) - ((x2 * t) >>> 30) / sdiv[k];
            if (t < 0)
                t = 0;
        end
        s = q30_round((x * t) >>> 30);
        t = longint'(Q30_ONE);
        for (int k = 0; k < 5; k++)
        begin
            t = longint'(Q30_ONE) - ((x2 * t) >>> 30) / cdiv[k];
            if (t < 0)
                t = 0;
        end
        c = q30_round(longint'(Q30_ONE) - ((x2 * t) >>> 30) / 2);
        case (quad_t'(quad))
            QUAD_0:  begin c_out = c;  s_out = s;  end
            QUAD_1:  begin c_out = -s; s_out = c;  end
            QUAD_2:  begin c_out = -c; s_out = -s; end
            default: begin c_out = s;  s_out = -c; end
        endcase
        c_out = near_zero_clear(c_out);
        s_out = near_zero_clear(s_out);
    endtask

    // Q31 to Q16.16 with halves rounded away from zero.
    function automatic longint round_link(input longint v);
        if (v >= 0)
            return (v + 16384) >>> 15;
        return -((-v + 16384) >>> 15);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip_pos(input longint v);
        if (v > 64'sd4194303)
            v = 64'sd4194303;
        if (v < -64'sd4194304)
            v = -64'sd4194304;
        return v[OUT_W-1:0];
    endfunction

    // Applies the links to the origin from joint six back to joint one.
    task automatic predict_tool_pos(input joint_angles_t ja, output tool_pos_t p);
        longint d [JOINTS];
        longint a [JOINTS];
        longint vx, vy, vz, ct, st, u, w, nx, ny, nz;
        d = '{longint'(link_reg[CFG_BASE_HEIGHT]), 0, 0, longint'(link_reg[CFG_WRIST1]),
              longint'(link_reg[CFG_WRIST2]), longint'(link_reg[CFG_WRIST3])};
        a = '{0, longint'(link_reg[CFG_UPPER_ARM]), longint'(link_reg[CFG_FOREARM]), 0, 0, 0};
        vx = 0;
        vy = 0;
        vz = 0;
        for (int i = JOINTS - 1; i >= 0; i--)
        begin
            angle_trig(ja.angle[i], ct, st);
            u = vx + a[i];
            w = TW_COS[i] * vy - TW_SIN[i] * vz;
            nx = round_link(ct * u - st * w);
            ny = round_link(st * u + ct * w);
            nz = TW_SIN[i] * vy + TW_COS[i] * vz + d[i];
            vx = nx;
            vy = ny;
            vz = nz;
        end
        p.x = clip_pos(vx);
        p.y = clip_pos(vy);
        p.z = clip_pos(vz);
    endtask

    // ------------------------------------------------------------------
    // Angle driver: each accepted beat is predicted at its acceptance edge, so the
    // prediction uses the link registers in force while that beat was in flight.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        joint_angles_t ja;
        tool_pos_t     p;
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.angle_1 <= '0;
            in_ch.angle_2 <= '0;
            in_ch.angle_3 <= '0;
            in_ch.angle_4 <= '0;
            in_ch.angle_5 <= '0;
            in_ch.angle_6 <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                ja.angle = '{in_ch.angle_1, in_ch.angle_2, in_ch.angle_3,
                             in_ch.angle_4, in_ch.angle_5, in_ch.angle_6};
                predict_tool_pos(ja, p);
                expected_pos.push_back(p);
            end
            // A new beat is offered only when the current one is gone; valid gets
            // at most one assignment per edge.
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_poses.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    ja = pending_poses.pop_front();
                    in_ch.angle_1 <= ja.angle[0];
                    in_ch.angle_2 <= ja.angle[1];
                    in_ch.angle_3 <= ja.angle[2];
                    in_ch.angle_4 <= ja.angle[3];
                    in_ch.angle_5 <= ja.angle[4];
                    in_ch.angle_6 <= ja.angle[5];
                    in_ch.valid   <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Position monitor: compares every accepted result beat with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        tool_pos_t p;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_pos.size() == 0)
                begin
                    $error("result beat with no prediction waiting: x %0d y %0d z %0d",
                           out_ch.x_pos, out_ch.y_pos, out_ch.z_pos);
                    fail_count++;
                end
                else
                begin
                    p = expected_pos.pop_front();
                    if (out_ch.x_pos !== p.x)
                    begin
                        $error("x_pos expected %0d actual %0d", p.x, out_ch.x_pos);
                        fail_count++;
                    end
                    if (out_ch.y_pos !== p.y)
                    begin
                        $error("y_pos expected %0d actual %0d", p.y, out_ch.y_pos);
                        fail_count++;
                    end
                    if (out_ch.z_pos !== p.z)
                    begin
                        $error("z_pos expected %0d actual %0d", p.z, out_ch.z_pos);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dh_forward_kinematics_6dof_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------

    // One beat on the configuration channel; the shadow follows on acceptance.
    // Valid stays high between back-to-back writes and is dropped by the caller.
    task automatic write_link(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx <= CFG_WRIST3)
            link_reg[idx] = val;
    endtask

    task automatic write_all_links(input logic signed [REG_W-1:0] vals [JOINTS]);
        for (int i = 0; i < JOINTS; i++)
            write_link(CFG_IDX_W'(i), vals[i]);
        // Indexes past the last register must be ignored by the block.
        write_link(CFG_IDX_W'(CFG_WRIST3 + 1), REG_W'($urandom));
        write_link(CFG_IDX_W'(CFG_WRIST3 + 2), REG_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits until every queued beat was taken and every result came back, then
    // lets the pipeline settle.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_poses.size() > 0 || in_ch.valid || expected_pos.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [ANGLE_W-1:0] corners [10];
        corners = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                    16'h0001, 16'h3FFF, 16'h7FFF, 16'h0002, 16'hBFFF};
        // Most angles are uniform; some sit on quadrant edges and the near-zero band.
        if ($urandom_range(9) < 2)
            return corners[$urandom_range(9)] + ANGLE_W'($urandom_range(2)) - 16'd1;
        return ANGLE_W'($urandom);
    endfunction

    task automatic queue_random(input int n);
        joint_angles_t ja;
        for (int k = 0; k < n; k++)
        begin
            for (int j = 0; j < JOINTS; j++)
                ja.angle[j] = pick_angle();
            pending_poses.push_back(ja);
        end
    endtask

    task automatic queue_same(input logic [ANGLE_W-1:0] v);
        joint_angles_t ja;
        for (int j = 0; j < JOINTS; j++)
            ja.angle[j] = v;
        pending_poses.push_back(ja);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic signed [REG_W-1:0] vals [JOINTS];
        joint_angles_t ja;
        int phase_items;

        fail_count     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        link_reg = '{RST_BASE_HEIGHT, RST_UPPER_ARM, RST_FOREARM,
                     RST_WRIST1, RST_WRIST2, RST_WRIST3};
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with the reset link values: quadrant edges, the near-zero
        // trig band (angles one and 0x3FFF land inside it), and the full scale.
        queue_same(16'h0000);
        queue_same(16'hFFFF);
        queue_same(16'h4000);
        queue_same(16'h8000);
        queue_same(16'hC000);
        queue_same(16'h0001);
        queue_same(16'h0002);
        queue_same(16'h3FFF);
        queue_same(16'h7FFF);
        queue_same(16'hBFFF);
        queue_same(16'h2000);
        queue_same(16'h5555);
        queue_same(16'hAAAA);
        for (int j = 0; j < JOINTS; j++)
        begin
            ja.angle = '{default: 16'h0000};
            ja.angle[j] = 16'h4000;
            pending_poses.push_back(ja);
        end
        wait_drained();

        // Link registers at their extreme values, first all at the maximum, then all at the minimum.
        vals = '{default: REG_MAX};
        write_all_links(vals);
        queue_same(16'h0000);
        queue_same(16'h8000);
        queue_same(16'h4000);
        wait_drained();
        vals = '{default: REG_MIN};
        write_all_links(vals);
        queue_same(16'h0000);
        queue_same(16'hC000);
        queue_same(16'h2000);
        wait_drained();

        // Random part: the four idle patterns, each under several link settings.
        phase_items = 100;
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            case (ph / 4)
                0: vals = '{RST_BASE_HEIGHT, RST_UPPER_ARM, RST_FOREARM,
                            RST_WRIST1, RST_WRIST2, RST_WRIST3};
                1: for (int i = 0; i < JOINTS; i++)
                       vals[i] = REG_W'($urandom);
                2: for (int i = 0; i < JOINTS; i++)
                       vals[i] = $urandom_range(1) ? REG_MAX : REG_MIN;
                default: for (int i = 0; i < JOINTS; i++)
                       vals[i] = REG_W'($signed($urandom_range(131072)) - 65536);
            endcase
            write_all_links(vals);
            queue_random(phase_items / 2);
            // Hold the sender back until the pipeline has emptied completely.
            if (ph == 5)
                wait_drained();
            queue_random(phase_items - phase_items / 2);
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        if (fail_count == 0 && expected_pos.size() == 0)
            $display("dh_forward_kinematics_6dof_core verification clean");
        else
            $display("dh_forward_kinematics_6dof_core verification failed");
        $finish;
    end

endmodule
